>>> rtl/cdh_pkg.sv
// Shared types and constants of the coverage depth histogram.
package cdh_pkg;

    localparam int OPCODE_W   = 2;
    localparam int POS_W      = 31;
    localparam int QUAL_W     = 8;
    localparam int BIN_IDX_W  = 10;
    localparam int BIN_OUT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Widest bin address over the whole parameter range (65536 bins).
    localparam int BIN_ADDR_MAX_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [QUAL_W-1:0] MIN_QUALITY_RST  = 8'd20;
    localparam logic [POS_W-1:0]  REGION_BEGIN_RST = 31'd0;
    localparam logic [POS_W-1:0]  REGION_END_RST   = 31'h7fffffff;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALIGN = 2'd0,
        OP_EMPTY = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_QUALITY  = 2'd0,
        CFG_REGION_BEGIN = 2'd1,
        CFG_REGION_END   = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_INC,
        CMD_READ,
        CMD_READ_ZERO
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                 kind;
        logic [BIN_ADDR_MAX_W-1:0] bin;
    } t_cmd;

endpackage

>>> rtl/cdh_intf.sv
// Handshake interfaces for the item and result channels.
interface cdh_in_if;
    logic                           valid;
    logic                           ready;
    logic [cdh_pkg::OPCODE_W-1:0]   opcode;
    logic [cdh_pkg::POS_W-1:0]      position;
    logic [cdh_pkg::QUAL_W-1:0]     map_quality;
    logic                           last_of_locus;
    logic [cdh_pkg::BIN_IDX_W-1:0]  bin_index;

    modport source (output valid, opcode, position, map_quality, last_of_locus, bin_index,
                    input ready);
    modport sink (input valid, opcode, position, map_quality, last_of_locus, bin_index,
                  output ready);
endinterface

interface cdh_out_if;
    logic                           valid;
    logic                           ready;
    logic [cdh_pkg::BIN_OUT_W-1:0]  bin_count;

    modport source (output valid, bin_count, input ready);
    modport sink (input valid, bin_count, output ready);
endinterface

>>> rtl/cdh_front.sv
// Front end: configuration registers, good-alignment count and command issue.
module cdh_front #(
    parameter int NUM_BINS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cdh_in_if.sink                           i_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cdh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cdh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_q_full,
    input  logic                             i_init_done,
    output logic                             o_push,
    output cdh_pkg::t_cmd                    o_cmd
);
    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam logic [ADDR_W-1:0] TOP_BIN = ADDR_W'(NUM_BINS - 1);

    logic [cdh_pkg::QUAL_W-1:0] r_min_quality;
    logic [cdh_pkg::POS_W-1:0]  r_region_begin;
    logic [cdh_pkg::POS_W-1:0]  r_region_end;
    logic [ADDR_W-1:0]          r_good;
    logic [ADDR_W-1:0]          n_good;
    logic [ADDR_W-1:0]          good_inc;
    logic                       accept;
    logic                       in_region;

    assign o_cfg_ready  = 1'b1;
    assign i_item.ready = !i_q_full && i_init_done;

    always_comb begin
        accept    = i_item.valid && i_item.ready;
        in_region = (i_item.position >= r_region_begin) && (i_item.position < r_region_end);
        if ((i_item.map_quality >= r_min_quality) && (r_good != TOP_BIN)) begin
            good_inc = ADDR_W'(r_good + 1'b1);
        end else begin
            good_inc = r_good;
        end

        n_good = r_good;
        o_push = 1'b0;
        o_cmd  = '{kind: cdh_pkg::CMD_INC, bin: '0};
        if (accept) begin
            unique case (i_item.opcode)
                cdh_pkg::OP_ALIGN: begin
                    if (i_item.last_of_locus) begin
                        o_push    = in_region;
                        o_cmd.bin = cdh_pkg::BIN_ADDR_MAX_W'(good_inc);
                        n_good    = '0;
                    end else begin
                        n_good = good_inc;
                    end
                end
                cdh_pkg::OP_EMPTY: begin
                    o_push    = in_region;
                    o_cmd.bin = cdh_pkg::BIN_ADDR_MAX_W'(r_good);
                    n_good    = '0;
                end
                cdh_pkg::OP_READ: begin
                    o_push     = 1'b1;
                    o_cmd.bin  = cdh_pkg::BIN_ADDR_MAX_W'(i_item.bin_index);
                    o_cmd.kind = (int'(i_item.bin_index) < NUM_BINS) ? cdh_pkg::CMD_READ
                                                                    : cdh_pkg::CMD_READ_ZERO;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_quality  <= cdh_pkg::MIN_QUALITY_RST;
            r_region_begin <= cdh_pkg::REGION_BEGIN_RST;
            r_region_end   <= cdh_pkg::REGION_END_RST;
            r_good         <= '0;
        end else begin
            r_good <= n_good;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    cdh_pkg::CFG_MIN_QUALITY:  r_min_quality  <= i_cfg_data[cdh_pkg::QUAL_W-1:0];
                    cdh_pkg::CFG_REGION_BEGIN: r_region_begin <= i_cfg_data;
                    cdh_pkg::CFG_REGION_END:   r_region_end   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> rtl/cdh_queue.sv
// Short command queue between the front end and the histogram back end.
module cdh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cdh_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    output logic          o_valid,
    output cdh_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    cdh_pkg::t_cmd                r_slot [cdh_pkg::QUEUE_DEPTH];
    logic [cdh_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [cdh_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [cdh_pkg::QCNT_W-1:0]   r_count;
    logic [cdh_pkg::QCNT_W-1:0]   n_count;

    always_comb begin
        o_full  = (r_count == cdh_pkg::QCNT_W'(cdh_pkg::QUEUE_DEPTH));
        o_valid = (r_count != '0);
        o_cmd   = r_slot[r_rd_ptr];
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = cdh_pkg::QCNT_W'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = cdh_pkg::QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= cdh_pkg::QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= cdh_pkg::QPTR_W'(r_rd_ptr + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

>>> rtl/cdh_back.sv
// Back end: histogram memory with clearing pass, saturating update and result register.
module cdh_back #(
    parameter int NUM_BINS        = 1024,
    parameter int BIN_COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  cdh_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    output logic          o_init_done,
    cdh_out_if.source     o_result
);
    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(NUM_BINS - 1);

    logic [BIN_COUNT_WIDTH-1:0]      r_hist [NUM_BINS];
    logic                            r_clr_active;
    logic [ADDR_W-1:0]               r_clr_addr;
    logic                            r_s1_valid;
    cdh_pkg::t_cmd                   r_s1_cmd;
    logic [BIN_COUNT_WIDTH-1:0]      r_rd_data;
    logic                            r_out_valid;
    logic [cdh_pkg::BIN_OUT_W-1:0]   r_out_data;

    logic [ADDR_W-1:0]               s1_addr;
    logic [ADDR_W-1:0]               rd_addr;
    logic                            s1_is_inc;
    logic                            out_free;
    logic                            s1_done;
    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [BIN_COUNT_WIDTH-1:0]      wr_data;
    logic [BIN_COUNT_WIDTH-1:0]      sat_inc;
    logic                            load_out;
    logic [cdh_pkg::BIN_OUT_W-1:0]   n_out_data;

    always_comb begin
        s1_addr   = r_s1_cmd.bin[ADDR_W-1:0];
        rd_addr   = i_q_cmd.bin[ADDR_W-1:0];
        s1_is_inc = (r_s1_cmd.kind == cdh_pkg::CMD_INC);
        out_free  = !r_out_valid || o_result.ready;
        s1_done   = s1_is_inc || out_free;
        o_pop     = i_q_valid && !r_clr_active && (!r_s1_valid || s1_done);

        sat_inc = (r_rd_data == '1) ? r_rd_data : BIN_COUNT_WIDTH'(r_rd_data + 1'b1);
        wr_en   = r_clr_active || (r_s1_valid && s1_is_inc);
        wr_addr = r_clr_active ? r_clr_addr : s1_addr;
        wr_data = r_clr_active ? '0 : sat_inc;

        load_out   = r_s1_valid && !s1_is_inc && out_free;
        n_out_data = (r_s1_cmd.kind == cdh_pkg::CMD_READ) ?
                     cdh_pkg::BIN_OUT_W'(r_rd_data) : '0;
    end

    assign o_init_done       = !r_clr_active;
    assign o_result.valid    = r_out_valid;
    assign o_result.bin_count = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= ADDR_W'(r_clr_addr + 1'b1);
                if (r_clr_addr == TOP_ADDR) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd <= i_q_cmd;
        end
        if (load_out) begin
            r_out_data <= n_out_data;
        end
    end

    // A write landing on the bin being read in the same cycle is forwarded, so
    // consecutive updates of one bin see each other.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[wr_addr] <= wr_data;
        end
        if (o_pop) begin
            r_rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : r_hist[rd_addr];
        end
    end

endmodule

>>> rtl/coverage_depth_histogram.sv
// Top level of the coverage depth histogram.
//
// Items arrive on i_item: alignments (with mapping quality and a last-of-locus
// flag), empty-locus markers and histogram reads. Alignments at or above the
// configured quality raise a count; closing a locus inside the configured
// region increments the bin for that count, clamped to the top bin, with bins
// saturating. Each read item returns one bin on o_result; other items return
// nothing. Registers are written on the i_cfg_* channel, which is always ready.
// One item is accepted per cycle while the clearing pass is done and the queue
// has room. A read result passes through a queue slot, the memory read register
// and then the result register. The histogram memory's single read-modify-write
// port sets the item rate; a write to the bin just read is forwarded so
// back-to-back updates of one bin are exact. After reset a clearing pass zeroes
// the memory bin by bin, during which i_item.ready stays low. When the receiver
// stalls, the result register holds its item, the back end stops and a
// four-entry queue absorbs items until it fills and i_item.ready drops.
module coverage_depth_histogram #(
    parameter int NUM_BINS        = 1024,
    parameter int BIN_COUNT_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cdh_in_if.sink                           i_item,
    cdh_out_if.source                        o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cdh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cdh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    logic          push;
    cdh_pkg::t_cmd push_cmd;
    logic          q_full;
    logic          q_valid;
    cdh_pkg::t_cmd q_cmd;
    logic          pop;
    logic          init_done;

    cdh_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .i_init_done (init_done),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    cdh_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (pop)
    );

    cdh_back #(
        .NUM_BINS        (NUM_BINS),
        .BIN_COUNT_WIDTH (BIN_COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_init_done (init_done),
        .o_result    (o_result)
    );

endmodule

>>> test/tb.sv
// Self-checking testbench for the coverage depth histogram: random loci, reads and register phases.
module tb;
    localparam int                          NUM_BINS     = 1024;
    localparam logic [cdh_pkg::OPCODE_W-1:0] OP_UNUSED   = 2'd3;
    localparam logic [cdh_pkg::POS_W-1:0]   POS_MAX      = {cdh_pkg::POS_W{1'b1}};
    localparam int                          DRAIN_CYCLES = 16;
    localparam int                          HOLD_CYCLES  = 64;

    class depth_scoreboard;
        logic [cdh_pkg::QUAL_W-1:0]    min_quality;
        logic [cdh_pkg::POS_W-1:0]     region_begin;
        logic [cdh_pkg::POS_W-1:0]     region_end;
        int                            good_count;
        logic [cdh_pkg::BIN_OUT_W-1:0] depth_bins [NUM_BINS];
        logic [cdh_pkg::BIN_OUT_W-1:0] pending_bin_counts [$];
        int                            errors;

        function new();
            min_quality  = cdh_pkg::MIN_QUALITY_RST;
            region_begin = cdh_pkg::REGION_BEGIN_RST;
            region_end   = cdh_pkg::REGION_END_RST;
            good_count   = 0;
            errors       = 0;
            foreach (depth_bins[i]) depth_bins[i] = '0;
        endfunction

        function void write_reg(cdh_pkg::t_cfg_reg r, logic [cdh_pkg::CFG_DATA_W-1:0] d);
            case (r)
                cdh_pkg::CFG_MIN_QUALITY:  min_quality  = d[cdh_pkg::QUAL_W-1:0];
                cdh_pkg::CFG_REGION_BEGIN: region_begin = d;
                cdh_pkg::CFG_REGION_END:   region_end   = d;
                default: ;
            endcase
        endfunction

        // The count never exceeds the top bin, so it indexes the histogram directly.
        function void close_locus(logic [cdh_pkg::POS_W-1:0] pos);
            if (pos >= region_begin && pos < region_end) begin
                if (depth_bins[good_count] != '1) depth_bins[good_count]++;
            end
            good_count = 0;
        endfunction

        function void note_item(logic [cdh_pkg::OPCODE_W-1:0] op, logic [cdh_pkg::POS_W-1:0] pos,
                                logic [cdh_pkg::QUAL_W-1:0] qual, bit last,
                                logic [cdh_pkg::BIN_IDX_W-1:0] idx);
            case (op)
                cdh_pkg::OP_ALIGN: begin
                    if (qual >= min_quality && good_count < NUM_BINS - 1) good_count++;
                    if (last) close_locus(pos);
                end
                cdh_pkg::OP_EMPTY: close_locus(pos);
                cdh_pkg::OP_READ:
                    pending_bin_counts.push_back(idx < NUM_BINS ? depth_bins[idx] : '0);
                default: ;
            endcase
        endfunction

        function void check_result(logic [cdh_pkg::BIN_OUT_W-1:0] got);
            logic [cdh_pkg::BIN_OUT_W-1:0] want;
            if (pending_bin_counts.size() == 0) begin
                $error("bin_count: expected no item, actual %0d", got);
                errors++;
            end else begin
                want = pending_bin_counts.pop_front();
                if (got !== want) begin
                    $error("bin_count: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_bin_counts.size();
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [cdh_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [cdh_pkg::CFG_DATA_W-1:0] i_cfg_data;

    cdh_in_if  item_if ();
    cdh_out_if result_if ();

    coverage_depth_histogram #(
        .NUM_BINS        (NUM_BINS),
        .BIN_COUNT_WIDTH (32)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    depth_scoreboard sb = new();

    bit gaps_on;
    bit stall_on;
    bit hold_req;
    bit hold_on;
    int accepted_items;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) sb.check_result(result_if.bin_count);
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        hold_on = 1'b0;
        result_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_on = 1'b1;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on  = 1'b0;
                hold_req = 1'b0;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [cdh_pkg::POS_W-1:0] rand_pos();
        longint base;
        longint span;
        base = 0;
        case ($urandom_range(0, 5))
            0: base = longint'(sb.region_begin) + $urandom_range(0, 4) - 2;
            1: base = longint'(sb.region_end) + $urandom_range(0, 4) - 2;
            2: begin
                span = longint'(sb.region_end) - longint'(sb.region_begin);
                if (span > 0) base = longint'(sb.region_begin) + longint'($urandom) % span;
                else base = longint'(sb.region_begin);
            end
            3: base = longint'($urandom) & longint'(POS_MAX);
            4: base = 0;
            default: base = longint'(POS_MAX);
        endcase
        if (base < 0) base = 0;
        if (base > longint'(POS_MAX)) base = longint'(POS_MAX);
        return base[cdh_pkg::POS_W-1:0];
    endfunction

    function automatic logic [cdh_pkg::QUAL_W-1:0] rand_qual();
        int q;
        case ($urandom_range(0, 3))
            0, 1: q = int'(sb.min_quality) + $urandom_range(0, 2) - 1;
            2: q = $urandom_range(0, 255);
            default: q = $urandom_range(0, 1) ? 255 : 0;
        endcase
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[cdh_pkg::QUAL_W-1:0];
    endfunction

    function automatic logic [cdh_pkg::BIN_IDX_W-1:0] rand_bin();
        case ($urandom_range(0, 7))
            0: return cdh_pkg::BIN_IDX_W'($urandom_range(0, NUM_BINS - 1));
            1: return cdh_pkg::BIN_IDX_W'(NUM_BINS - 1);
            default: return cdh_pkg::BIN_IDX_W'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic send_item(input logic [cdh_pkg::OPCODE_W-1:0] op,
                             input logic [cdh_pkg::POS_W-1:0] pos,
                             input logic [cdh_pkg::QUAL_W-1:0] qual, input bit last,
                             input logic [cdh_pkg::BIN_IDX_W-1:0] idx);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        item_if.valid         <= 1'b1;
        item_if.opcode        <= op;
        item_if.position      <= pos;
        item_if.map_quality   <= qual;
        item_if.last_of_locus <= last;
        item_if.bin_index     <= idx;
        do @(posedge i_clk); while (!item_if.ready);
        sb.note_item(op, pos, qual, last, idx);
        if (op != OP_UNUSED) accepted_items++;
    endtask

    task automatic send_read(input logic [cdh_pkg::BIN_IDX_W-1:0] idx);
        send_item(cdh_pkg::OP_READ, cdh_pkg::POS_W'($urandom), cdh_pkg::QUAL_W'($urandom),
                  1'($urandom_range(0, 1)), idx);
    endtask

    task automatic wait_results();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Updates that produce no result may still sit in the queue after the
    // last read has returned, so allow them to retire as well.
    task automatic wait_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input cdh_pkg::t_cfg_reg r,
                             input logic [cdh_pkg::CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(r, d);
    endtask

    task automatic set_regs(input logic [cdh_pkg::QUAL_W-1:0] q,
                            input logic [cdh_pkg::POS_W-1:0] b,
                            input logic [cdh_pkg::POS_W-1:0] e);
        write_reg(cdh_pkg::CFG_MIN_QUALITY, cdh_pkg::CFG_DATA_W'(q));
        write_reg(cdh_pkg::CFG_REGION_BEGIN, b);
        write_reg(cdh_pkg::CFG_REGION_END, e);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_locus();
        int                        n;
        logic [cdh_pkg::POS_W-1:0] pos;
        n   = $urandom_range(0, 6);
        pos = rand_pos();
        if (n == 0) begin
            send_item(cdh_pkg::OP_EMPTY, pos, cdh_pkg::QUAL_W'($urandom),
                      1'($urandom_range(0, 1)), cdh_pkg::BIN_IDX_W'($urandom));
        end else begin
            for (int i = 0; i < n; i++) begin
                send_item(cdh_pkg::OP_ALIGN, pos, rand_qual(), i == n - 1,
                          cdh_pkg::BIN_IDX_W'($urandom));
            end
        end
    endtask

    task automatic run_phase(input int n_items);
        int stop;
        int pick;
        stop = accepted_items + n_items;
        while (accepted_items < stop) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) begin
                send_locus();
            end else if (pick < 16) begin
                send_read(rand_bin());
            end else if (pick == 16) begin
                send_item(OP_UNUSED, cdh_pkg::POS_W'($urandom), cdh_pkg::QUAL_W'($urandom),
                          1'($urandom_range(0, 1)), cdh_pkg::BIN_IDX_W'($urandom));
            end else if (pick == 17) begin
                // Alignments left open; the next close takes them into its count.
                repeat ($urandom_range(1, 3))
                    send_item(cdh_pkg::OP_ALIGN, rand_pos(), rand_qual(), 1'b0,
                              cdh_pkg::BIN_IDX_W'($urandom));
            end else if (pick == 18) begin
                send_item(cdh_pkg::OP_EMPTY, cdh_pkg::POS_W'($urandom),
                          cdh_pkg::QUAL_W'($urandom), 1'($urandom_range(0, 1)),
                          cdh_pkg::BIN_IDX_W'($urandom));
            end else begin
                wait_results();
            end
        end
    endtask

    task automatic random_knobs();
        gaps_on  = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
    endtask

    initial begin
        logic [cdh_pkg::POS_W-1:0] b;
        i_rst_n               <= 1'b0;
        i_cfg_valid           <= 1'b0;
        i_cfg_index           <= cdh_pkg::CFG_MIN_QUALITY;
        i_cfg_data            <= '0;
        item_if.valid         <= 1'b0;
        item_if.opcode        <= cdh_pkg::OP_ALIGN;
        item_if.position      <= '0;
        item_if.map_quality   <= '0;
        item_if.last_of_locus <= 1'b0;
        item_if.bin_index     <= '0;
        gaps_on        = 1'b1;
        stall_on       = 1'b1;
        hold_req       = 1'b0;
        accepted_items = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset register values.
        send_item(cdh_pkg::OP_ALIGN, 5, 20, 1'b0, '0);
        send_item(cdh_pkg::OP_ALIGN, 5, 19, 1'b0, '1);
        send_item(cdh_pkg::OP_ALIGN, 5, 255, 1'b1, '0);
        send_item(cdh_pkg::OP_EMPTY, 0, cdh_pkg::QUAL_W'($urandom), 1'($urandom_range(0, 1)),
                  cdh_pkg::BIN_IDX_W'($urandom));
        send_item(cdh_pkg::OP_EMPTY, POS_MAX, '1, 1'b1, '1);
        send_item(cdh_pkg::OP_ALIGN, cdh_pkg::POS_W'(POS_MAX - 1), 0, 1'b1, '0);
        send_item(OP_UNUSED, POS_MAX, '1, 1'b1, '1);
        send_item(cdh_pkg::OP_ALIGN, 9, 200, 1'b0, '0);
        send_item(cdh_pkg::OP_EMPTY, 9, '0, 1'b0, '0);
        send_item(cdh_pkg::OP_ALIGN, POS_MAX, 255, 1'b1, '0);
        send_item(cdh_pkg::OP_EMPTY, 7, '0, 1'b0, '0);
        send_item(cdh_pkg::OP_READ, POS_MAX, '1, 1'b1, 0);
        send_read(1);
        send_read(2);
        send_read(cdh_pkg::BIN_IDX_W'(NUM_BINS - 1));
        send_item(cdh_pkg::OP_READ, '0, '0, 1'b0, 3);

        // Empty region: nothing is counted.
        wait_idle();
        set_regs(0, 100, 100);
        send_item(cdh_pkg::OP_ALIGN, 100, 0, 1'b1, '0);
        send_item(cdh_pkg::OP_EMPTY, 100, '0, 1'b0, '0);
        send_read(0);
        send_read(1);

        // Region at the top of the coordinate range, strictest quality.
        wait_idle();
        set_regs(255, cdh_pkg::POS_W'(POS_MAX - 1), POS_MAX);
        send_item(cdh_pkg::OP_ALIGN, cdh_pkg::POS_W'(POS_MAX - 1), 255, 1'b0, '0);
        send_item(cdh_pkg::OP_ALIGN, cdh_pkg::POS_W'(POS_MAX - 1), 254, 1'b1, '0);
        send_item(cdh_pkg::OP_EMPTY, cdh_pkg::POS_W'(POS_MAX - 2), '0, 1'b0, '0);
        send_read(1);
        send_read(0);

        // Reset values again; the result side holds off while reads pile up.
        wait_idle();
        set_regs(cdh_pkg::MIN_QUALITY_RST, cdh_pkg::REGION_BEGIN_RST, cdh_pkg::REGION_END_RST);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        wait (hold_on);
        repeat (16) send_read(rand_bin());
        random_knobs();
        run_phase(70);

        wait_idle();
        set_regs(0, 0, POS_MAX);
        random_knobs();
        run_phase(70);

        wait_idle();
        set_regs(255, 0, POS_MAX);
        random_knobs();
        run_phase(70);

        wait_idle();
        b = cdh_pkg::POS_W'($urandom);
        set_regs(cdh_pkg::QUAL_W'($urandom), b,
                 (b > POS_MAX - 1000) ? POS_MAX
                                      : cdh_pkg::POS_W'(b + $urandom_range(1, 1000)));
        random_knobs();
        run_phase(70);

        wait_idle();
        set_regs(cdh_pkg::QUAL_W'($urandom), POS_MAX, 0);
        random_knobs();
        run_phase(60);

        wait_idle();
        set_regs(cdh_pkg::QUAL_W'($urandom), 0, 0);
        random_knobs();
        run_phase(40);

        wait_idle();
        set_regs(cdh_pkg::QUAL_W'($urandom), cdh_pkg::POS_W'($urandom),
                 cdh_pkg::POS_W'($urandom));
        random_knobs();
        run_phase(70);

        wait_idle();
        set_regs(cdh_pkg::QUAL_W'($urandom_range(0, 60)), 0, POS_MAX);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        run_phase(80);

        wait_idle();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
